// ----- rtl/brhp_pkg.sv -----
`timescale 1ns / 1ps
package brhp_pkg;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_UNIT,
    PH_UNITWS,
    PH_SPEC,
    PH_FIRST,
    PH_DASHED
  } phase_e;

  typedef enum logic [2:0] {
    ST_ABSENT   = 3'd0,
    ST_SINGLE   = 3'd1,
    ST_MULTIPLE = 3'd2,
    ST_UNSAT    = 3'd3,
    ST_MALFORM  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_CLOSE,
    CMD_FINISH
  } cmd_e;

  localparam logic [62:0] VAL_MAX = {63{1'b1}};
  localparam logic [7:0]  CH_EQ    = 8'h3d;
  localparam logic [7:0]  CH_COMMA = 8'h2c;
  localparam logic [7:0]  CH_DASH  = 8'h2d;
  localparam logic [7:0]  CH_SP    = 8'h20;
  localparam logic [7:0]  CH_TAB   = 8'h09;

  // front-to-back queue entry: a finished spec or the end of header
  typedef struct packed {
    cmd_e        cmd;
    logic        has_first;
    logic        has_second;
    logic [63:0] first_val;
    logic [63:0] second_val;
    logic [63:0] total;
    logic        malformed;
    logic        lead;
  } job_t;

  function automatic logic [7:0] unit_letter(input logic [2:0] idx);
    logic [7:0] r;
    begin
      unique case (idx)
        3'd0: r = 8'h62;
        3'd1: r = 8'h79;
        3'd2: r = 8'h74;
        3'd3: r = 8'h65;
        3'd4: r = 8'h73;
        default: r = 8'h00;
      endcase
      return r;
    end
  endfunction

endpackage

// ----- rtl/brhp_front.sv -----
`timescale 1ns / 1ps
module brhp_front #(
  parameter int MaxRanges = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [7:0]         ch_i,
  input  logic               no_char_i,
  input  logic               ends_header_i,
  input  logic [63:0]        total_size_i,
  output logic               job_valid_o,
  input  logic               job_stall_i,
  output brhp_pkg::job_t     job_o
);
  import brhp_pkg::*;

  localparam int CW = $clog2(MaxRanges + 2);

  phase_e        phase_q, phase_d;
  logic [2:0]    unit_q, unit_d;
  logic [62:0]   acc1_q, acc1_d, acc2_q, acc2_d;
  logic          hf_q, hf_d, hs_q, hs_d, ws_q, ws_d;
  logic [CW-1:0] spec_q, spec_d;
  logic          mal_q, mal_d;

  logic          go, emit;
  job_t          job;
  logic [7:0]    c, low;
  logic          is_ws, is_dig;
  logic [3:0]    dval;
  logic [62:0]   acc_sel, acc_new;
  logic [66:0]   prod;
  logic          ovf, dig_to2;

  assign stall_o = job_valid_o & job_stall_i;
  assign go      = valid_i & ~stall_o;

  always_comb begin
    c      = ch_i;
    low    = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    is_ws  = (c == CH_SP) || (c == CH_TAB);
    is_dig = (c >= 8'h30) && (c <= 8'h39);
    dval   = c[3:0];
    dig_to2 = (phase_q == PH_DASHED);
    acc_sel = dig_to2 ? acc2_q : acc1_q;
    prod    = {4'd0, acc_sel} * 67'd10 + {63'd0, dval};
    ovf     = (prod[66:63] != 4'd0);
    acc_new = prod[62:0];
  end

  always_comb begin
    phase_d = phase_q; unit_d = unit_q; acc1_d = acc1_q; acc2_d = acc2_q;
    hf_d = hf_q; hs_d = hs_q; ws_d = ws_q; spec_d = spec_q; mal_d = mal_q;
    emit = 1'b0;
    job  = '0;
    job.total = total_size_i;
    if (go) begin
      if (!no_char_i && !mal_q) begin
        unique case (phase_q)
          PH_LEAD: begin
            if (!is_ws) begin
              if (c == CH_EQ) mal_d = 1'b1;
              else begin
                phase_d = PH_UNIT;
                if (low == unit_letter(unit_q)) unit_d = unit_q + 3'd1;
                else mal_d = 1'b1;
              end
            end
          end
          PH_UNIT: begin
            if (is_ws) phase_d = PH_UNITWS;
            else if (c == CH_EQ) begin
              if (unit_q == 3'd5) phase_d = PH_SPEC;
              else mal_d = 1'b1;
            end else if (unit_q < 3'd5 && low == unit_letter(unit_q)) unit_d = unit_q + 3'd1;
            else mal_d = 1'b1;
          end
          PH_UNITWS: begin
            if (!is_ws) begin
              if (c == CH_EQ && unit_q == 3'd5) phase_d = PH_SPEC;
              else mal_d = 1'b1;
            end
          end
          PH_SPEC: begin
            if (!(is_ws || c == CH_COMMA)) begin
              if (is_dig || c == CH_DASH) begin
                spec_d = spec_q + CW'(1);
                if (spec_q >= CW'(MaxRanges)) mal_d = 1'b1;
                if (is_dig) begin
                  phase_d = PH_FIRST;
                  hf_d = 1'b1;
                  if (ovf) mal_d = 1'b1;
                  else acc1_d = acc_new;
                end else phase_d = PH_DASHED;
              end else mal_d = 1'b1;
            end
          end
          PH_FIRST: begin
            if (is_dig) begin
              if (ws_q || ovf) mal_d = 1'b1;
              else acc1_d = acc_new;
            end else if (is_ws) ws_d = 1'b1;
            else if (c == CH_DASH) begin
              ws_d = 1'b0; phase_d = PH_DASHED;
            end else mal_d = 1'b1;
          end
          PH_DASHED: begin
            if (is_ws) begin
              if (hs_q) ws_d = 1'b1;
            end else if (is_dig) begin
              if (ws_q) mal_d = 1'b1;
              else if (ovf) begin
                mal_d = 1'b1; hs_d = 1'b1;
              end else begin
                hs_d = 1'b1; acc2_d = acc_new;
              end
            end else if (c == CH_COMMA) begin
              emit = 1'b1;
              job.cmd = CMD_CLOSE;
              job.has_first = hf_q; job.has_second = hs_q;
              job.first_val = {1'b0, acc1_q}; job.second_val = {1'b0, acc2_q};
              hf_d = 1'b0; hs_d = 1'b0; ws_d = 1'b0;
              acc1_d = '0; acc2_d = '0; phase_d = PH_SPEC;
            end else mal_d = 1'b1;
          end
          default: mal_d = 1'b1;
        endcase
      end
      if (ends_header_i) begin
        // finish beat also closes a spec ended by its own comma or still open
        job.cmd = CMD_FINISH;
        if (!emit) begin
          job.has_first  = (phase_d == PH_DASHED) && hf_d;
          job.has_second = (phase_d == PH_DASHED) && hs_d;
          job.first_val  = {1'b0, acc1_d};
          job.second_val = {1'b0, acc2_d};
        end
        job.second_val[63] = emit || (phase_d == PH_DASHED);
        job.malformed = mal_d || (phase_d == PH_UNIT) || (phase_d == PH_UNITWS)
                        || (phase_d == PH_FIRST);
        job.lead = (phase_d == PH_LEAD);
        emit = 1'b1;
        phase_d = PH_LEAD; unit_d = '0; acc1_d = '0; acc2_d = '0;
        hf_d = 1'b0; hs_d = 1'b0; ws_d = 1'b0; spec_d = '0; mal_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD; unit_q <= '0; acc1_q <= '0; acc2_q <= '0;
      hf_q <= 1'b0; hs_q <= 1'b0; ws_q <= 1'b0; spec_q <= '0; mal_q <= 1'b0;
      job_valid_o <= 1'b0;
    end else begin
      phase_q <= phase_d; unit_q <= unit_d; acc1_q <= acc1_d; acc2_q <= acc2_d;
      hf_q <= hf_d; hs_q <= hs_d; ws_q <= ws_d; spec_q <= spec_d; mal_q <= mal_d;
      if (!stall_o) job_valid_o <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && emit) job_o <= job;
  end

  a_unit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) unit_q <= 3'd5)
    else $error("unit progress out of range");
  a_spec_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spec_q <= CW'(MaxRanges + 1)) else $error("spec count out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |=> $stable(job_o)) else $error("queued job changed");
endmodule

// ----- rtl/brhp_back.sv -----
`timescale 1ns / 1ps
module brhp_back #(
  parameter int MaxRanges = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  output logic           job_stall_o,
  input  brhp_pkg::job_t job_i,
  output logic           valid_o,
  input  logic           stall_i,
  output logic           is_status_o,
  output logic [62:0]    range_first_o,
  output logic [62:0]    range_last_o,
  output logic [2:0]     status_o,
  output logic           last_of_run_o
);
  import brhp_pkg::*;

  localparam int IW = $clog2(MaxRanges + 1);
  localparam int AW = (MaxRanges > 1) ? $clog2(MaxRanges) : 1;

  logic [62:0]   start_mem [MaxRanges];
  logic [62:0]   end_mem [MaxRanges];
  logic [IW-1:0] stored_q, rd_q;
  logic          unsat_q, busy_q, mal_q;
  status_e       st_q;

  logic          take, out_free;
  logic          hf, hs, tneg, is_close;
  logic [62:0]   tv, s, f, first_c, last_c;
  logic          unsat, bad, store;
  status_e       st_c;
  logic          fin_mal;

  assign out_free    = ~valid_o | ~stall_i;
  assign job_stall_o = busy_q | ~out_free;
  assign take        = job_valid_i & ~job_stall_o;

  always_comb begin
    tneg = job_i.total[63];
    tv   = job_i.total[62:0];
    hf   = job_i.has_first;
    hs   = job_i.has_second;
    s    = job_i.second_val[62:0];
    f    = job_i.first_val[62:0];
    is_close = (job_i.cmd == CMD_CLOSE) ||
               (job_i.cmd == CMD_FINISH && job_i.second_val[63] && !job_i.malformed);
    unsat = 1'b0; bad = 1'b0; first_c = f; last_c = '0;
    if (!hf) begin
      if (!hs) bad = 1'b1;
      else if (s == '0) unsat = 1'b1;
      else if (tneg) bad = 1'b1;
      else if (tv == '0) unsat = 1'b1;
      else begin
        first_c = (s >= tv) ? '0 : tv - s;
        last_c  = tv - 63'd1;
      end
    end else if (!hs) begin
      if (tneg) last_c = VAL_MAX;
      else if (f >= tv) unsat = 1'b1;
      else last_c = tv - 63'd1;
    end else begin
      if (s < f) bad = 1'b1;
      else if (!tneg && f >= tv) unsat = 1'b1;
      else last_c = (!tneg && s > tv - 63'd1) ? tv - 63'd1 : s;
    end
    store = is_close && !unsat && !bad && (stored_q < IW'(MaxRanges));
    fin_mal = job_i.malformed || (is_close && bad);
    if (fin_mal) st_c = ST_MALFORM;
    else if (job_i.lead) st_c = ST_ABSENT;
    else if (stored_q == '0 && !store)
      st_c = (unsat_q || (is_close && unsat)) ? ST_UNSAT : ST_MALFORM;
    else if ((stored_q + IW'(store)) == IW'(1)) st_c = ST_SINGLE;
    else st_c = ST_MULTIPLE;
  end

  always_ff @(posedge clk_i) begin
    if (take && store) begin
      start_mem[stored_q[AW-1:0]] <= first_c;
      end_mem[stored_q[AW-1:0]]   <= last_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q <= '0; unsat_q <= 1'b0; busy_q <= 1'b0; mal_q <= 1'b0;
      rd_q <= '0; st_q <= ST_ABSENT; valid_o <= 1'b0;
    end else begin
      if (take) begin
        valid_o <= 1'b0;
        if (store) stored_q <= stored_q + IW'(1);
        if (is_close && unsat) unsat_q <= 1'b1;
        if (job_i.cmd == CMD_CLOSE && bad) mal_q <= 1'b1;
        if (job_i.cmd == CMD_FINISH) begin
          busy_q <= 1'b1; rd_q <= '0;
          st_q <= mal_q ? ST_MALFORM : st_c;
        end
      end else if (busy_q && out_free) begin
        valid_o <= 1'b1;
        if ((st_q == ST_SINGLE || st_q == ST_MULTIPLE) && rd_q < stored_q) begin
          rd_q <= rd_q + IW'(1);
        end else begin
          busy_q <= 1'b0; stored_q <= '0; unsat_q <= 1'b0; mal_q <= 1'b0;
          rd_q <= '0;
        end
      end else if (out_free) begin
        valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!take && busy_q && out_free) begin
      if ((st_q == ST_SINGLE || st_q == ST_MULTIPLE) && rd_q < stored_q) begin
        is_status_o   <= 1'b0;
        range_first_o <= start_mem[rd_q[AW-1:0]];
        range_last_o  <= end_mem[rd_q[AW-1:0]];
        status_o      <= 3'd0;
        last_of_run_o <= 1'b0;
      end else begin
        is_status_o   <= 1'b1;
        range_first_o <= '0;
        range_last_o  <= '0;
        status_o      <= st_q;
        last_of_run_o <= 1'b1;
      end
    end
  end

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !take) else $error("job taken while draining");
  a_stored_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= IW'(MaxRanges)) else $error("stored count out of range");
  a_rd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_q <= stored_q) else $error("read pointer past stored count");
endmodule

// ----- rtl/byte_range_header_parser.sv -----
`timescale 1ns / 1ps
// Parses an HTTP "bytes" Range header value one character per beat. The front
// part takes one character a cycle unless stalled; each finished spec and the
// header end pass through a one-entry queue to the back part, which clamps
// specs against total_size_i and stores up to MAX_RANGES ranges. After the
// closing beat is taken, the back part registers busy and then emits one beat
// per stored range (only for a single or multiple status) and then a status
// beat, one per cycle while the output does not stall. The input stalls while
// a queued job waits for the back part, which stays busy until its status beat
// is out.
module byte_range_header_parser #(
  parameter int MAX_RANGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  ch_i,
  input  logic        no_char_i,
  input  logic        ends_header_i,
  input  logic [63:0] total_size_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic        is_status_o,
  output logic [62:0] range_first_o,
  output logic [62:0] range_last_o,
  output logic [2:0]  status_o,
  output logic        last_of_run_o
);
  import brhp_pkg::*;

  logic jv, js;
  job_t job;

  brhp_front #(.MaxRanges(MAX_RANGES)) u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .ch_i, .no_char_i, .ends_header_i,
    .total_size_i, .job_valid_o(jv), .job_stall_i(js), .job_o(job)
  );

  brhp_back #(.MaxRanges(MAX_RANGES)) u_back (
    .clk_i, .rst_ni, .job_valid_i(jv), .job_stall_o(js), .job_i(job),
    .valid_o, .stall_i, .is_status_o, .range_first_o, .range_last_o,
    .status_o, .last_of_run_o
  );
endmodule
